>>> rtl/srs_pkg.sv
// Shared types and constants for the servo ramp sequencer.
package srs_pkg;

	// Table and field sizes
	localparam int MAX_STEPS = 16;
	localparam int STEP_W    = $clog2(MAX_STEPS);
	localparam int CNT_W     = STEP_W + 1;
	localparam int POS_W     = 16;
	localparam int SPD_W     = 10;
	localparam int MOVE_W    = 11;
	localparam int DELAY_W   = 16;
	localparam int PROD_W    = MOVE_W + SPD_W;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Timing constants
	localparam int MS_PER_SEC = 1000;

	// Reset values of the configuration registers
	localparam logic [SPD_W-1:0] MOVE_SPEED_RST = SPD_W'(1);
	localparam logic [POS_W-1:0] MIN_LIMIT_RST  = POS_W'(0);
	localparam logic [POS_W-1:0] MAX_LIMIT_RST  = POS_W'(180);
	localparam logic [CNT_W-1:0] STEP_COUNT_RST = CNT_W'(1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOVE_SPEED = 2'd0,
		CFG_MIN_LIMIT  = 2'd1,
		CFG_MAX_LIMIT  = 2'd2,
		CFG_STEP_COUNT = 2'd3
	} cfg_idx_t;

	// Item commands
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_DIRECT = 2'd1,
		CMD_SEQ    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_EX   = 3'b100
	} state_t;

	// One step of the table
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [SPD_W-1:0] spd;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/srs_ram.sv
// Generic single-port-write, registered-read RAM.
module srs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/servo_ramp_sequencer.sv
// Servo ramp sequencer top level: direct ramp and table playback on ms ticks.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    cmd, entry_index, entry_position,
//                                             entry_speed, target
// output    out        out_valid / out_stall  position, drive_value, step_index,
//                                             sequence_done, on_limit, at_target
// config    in         cfg_we                 cfg_index, cfg_data
//
// Each transaction passes through three steps: accept and table read, move-rate
// product, then execute and write back into the result register.
// The step table is one registered-read RAM; the next transaction is taken
// only after the previous one has written back, so accesses never overlap.
// in_stall is high while a transaction is in flight; a stalled result holds
// the execute stage until the result register frees up.
// Reset sets state and config only; table contents are undefined until loaded.
module servo_ramp_sequencer
	import srs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [3:0]           entry_index,
	input  logic [POS_W-1:0]     entry_position,
	input  logic [SPD_W-1:0]     entry_speed,
	input  logic [POS_W-1:0]     target,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [POS_W-1:0]     position,
	output logic [POS_W-1:0]     drive_value,
	output logic [3:0]           step_index,
	output logic                 sequence_done,
	output logic                 on_limit,
	output logic                 at_target,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [POS_W-1:0]   min_limit_q;
	logic [POS_W-1:0]   max_limit_q;
	logic [CNT_W-1:0]   step_count_q;

	// Block state
	state_t             state_q;
	logic [POS_W-1:0]   pos_q;
	logic [STEP_W-1:0]  cur_step_q;
	logic [MOVE_W-1:0]  move_el_q;
	logic [DELAY_W-1:0] delay_el_q;
	logic [SPD_W-1:0]   active_speed_q;
	logic               done_q;

	// Transaction registers
	cmd_t               cmd_q;
	logic [POS_W-1:0]   target_q;
	logic [STEP_W-1:0]  step_q;
	logic [PROD_W-1:0]  prod_s2;
	logic [POS_W-1:0]   goal_s2;
	logic [SPD_W-1:0]   spd_s2;

	// Result register
	logic               out_valid_q;
	logic [POS_W-1:0]   position_q;
	logic [POS_W-1:0]   drive_q;
	logic [STEP_W-1:0]  step_index_q;
	logic               done_out_q;
	logic               limit_q;
	logic               at_target_q;

	logic               in_acc;
	logic               ex_go;
	logic [CNT_W-1:0]   eff_cnt;
	logic [STEP_W-1:0]  step_eff;
	entry_t             wr_entry;
	entry_t             rd_entry;
	logic [ENTRY_W-1:0] rd_raw;
	logic [SPD_W-1:0]   speed_sel;

	logic               ramp;
	logic               fire_move;
	logic               fire_delay;
	logic               there;
	logic               advance;
	logic [POS_W-1:0]   pos_nx;
	logic [CNT_W-1:0]   step_inc;
	logic               wrap;
	logic               lim_nx;

	assign in_acc   = in_valid && state_q[0];
	assign in_stall = !state_q[0];
	assign ex_go    = (state_q == ST_EX) && (!out_valid_q || !out_stall);

	// Clamp step count into 1..MAX_STEPS and restart an index beyond it
	always_comb begin
		if (step_count_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (step_count_q > CNT_W'(MAX_STEPS)) begin
			eff_cnt = CNT_W'(MAX_STEPS);
		end else begin
			eff_cnt = step_count_q;
		end
		step_eff = ({1'b0, cur_step_q} >= eff_cnt) ? '0 : cur_step_q;
	end

	// Step table
	assign wr_entry.pos = entry_position;
	assign wr_entry.spd = entry_speed;

	srs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_STEPS)
	) u_table (
		.clk  (clk),
		.we   (in_acc && (cmd_t'(cmd) == CMD_LOAD)),
		.waddr(entry_index[STEP_W-1:0]),
		.wdata(wr_entry),
		.re   (in_acc && (cmd_t'(cmd) == CMD_SEQ)),
		.raddr(step_eff),
		.rdata(rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_RD;
				ST_RD:   state_q <= ST_EX;
				ST_EX:   if (ex_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= cmd_t'(cmd);
			target_q <= target;
			step_q   <= step_eff;
		end
	end

	// Move-rate product: elapsed * speed > 1000 means elapsed > 1000 / speed
	assign speed_sel = ((cmd_q == CMD_SEQ) && (rd_entry.spd != '0)) ? rd_entry.spd
	                                                                 : active_speed_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			prod_s2 <= PROD_W'(move_el_q) * PROD_W'(speed_sel);
			goal_s2 <= (cmd_q == CMD_SEQ) ? rd_entry.pos : target_q;
			spd_s2  <= (cmd_q == CMD_SEQ) ? rd_entry.spd : active_speed_q;
		end
	end

	// Execute: ramp, delay and step advance
	always_comb begin
		ramp       = (cmd_q == CMD_DIRECT) || ((cmd_q == CMD_SEQ) && (spd_s2 != '0));
		fire_move  = prod_s2 > PROD_W'(MS_PER_SEC);
		fire_delay = delay_el_q >= goal_s2;
		there      = goal_s2 == pos_q;
		pos_nx     = pos_q;
		if (ramp && fire_move && !there) begin
			pos_nx = (pos_q < goal_s2) ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
		end
		advance  = ramp ? (pos_nx == goal_s2) : fire_delay;
		step_inc = {1'b0, step_q} + CNT_W'(advance);
		wrap     = step_inc >= eff_cnt;
		lim_nx   = (pos_nx >= max_limit_q) || (pos_nx <= min_limit_q);
	end

	// Write back state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_limit_q    <= MIN_LIMIT_RST;
			max_limit_q    <= MAX_LIMIT_RST;
			step_count_q   <= STEP_COUNT_RST;
			active_speed_q <= MOVE_SPEED_RST;
			pos_q          <= '0;
			cur_step_q     <= '0;
			move_el_q      <= '0;
			delay_el_q     <= '0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MOVE_SPEED: active_speed_q <= cfg_data[SPD_W-1:0];
					CFG_MIN_LIMIT:  min_limit_q    <= cfg_data[POS_W-1:0];
					CFG_MAX_LIMIT:  max_limit_q    <= cfg_data[POS_W-1:0];
					CFG_STEP_COUNT: step_count_q   <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (ex_go) begin
				if (ramp) begin
					pos_q <= pos_nx;
					if (fire_move) begin
						move_el_q <= '0;
					end else if (move_el_q != '1) begin
						move_el_q <= move_el_q + MOVE_W'(1);
					end
				end
				if (cmd_q == CMD_SEQ) begin
					if (spd_s2 != '0) begin
						active_speed_q <= spd_s2;
					end else if (fire_delay) begin
						delay_el_q <= '0;
					end else if (delay_el_q != '1) begin
						delay_el_q <= delay_el_q + DELAY_W'(1);
					end
					cur_step_q <= wrap ? '0 : step_inc[STEP_W-1:0];
					done_q     <= wrap;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ex_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ex_go) begin
			position_q   <= pos_nx;
			drive_q      <= ((cmd_q == CMD_DIRECT) && lim_nx) ? goal_s2 : pos_nx;
			step_index_q <= (cmd_q == CMD_SEQ) ? (wrap ? '0 : step_inc[STEP_W-1:0])
			                                   : cur_step_q;
			done_out_q   <= (cmd_q == CMD_SEQ) ? wrap : done_q;
			limit_q      <= lim_nx;
			at_target_q  <= ramp && there;
		end
	end

	assign out_valid     = out_valid_q;
	assign position      = position_q;
	assign drive_value   = drive_q;
	assign step_index    = step_index_q;
	assign sequence_done = done_out_q;
	assign on_limit      = limit_q;
	assign at_target     = at_target_q;

endmodule

>>> rtl/srs_checker.sv
// Port-level checker for the servo ramp sequencer, bound to the top level.
module srs_checker
	import srs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [1:0]           cmd,
	input logic [3:0]           entry_index,
	input logic [POS_W-1:0]     entry_position,
	input logic [SPD_W-1:0]     entry_speed,
	input logic [POS_W-1:0]     target,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [POS_W-1:0]     position,
	input logic [POS_W-1:0]     drive_value,
	input logic [3:0]           step_index,
	input logic                 sequence_done,
	input logic                 on_limit,
	input logic                 at_target
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(drive_value)
			&& $stable(step_index) && $stable(sequence_done) && $stable(on_limit)
			&& $stable(at_target))
		else $error("stalled result changed");

	// Hold a stalled input transaction
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(entry_index)
			&& $stable(entry_position) && $stable(entry_speed) && $stable(target))
		else $error("stalled input transaction changed");

	// Go busy after taking a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// A new result follows only a busy period
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without transaction in flight");

	// A wrap leaves the index at the first step
	a_done_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_done |-> step_index == 4'd0)
		else $error("done flag with nonzero step index");

endmodule

bind servo_ramp_sequencer srs_checker u_srs_checker (.*);
